// ----- design/fgn_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fgn_pkg
// Shared types, codes and helpers of the fractal gradient noise block.
// ----------------------------------------------------------------------------
package fgn_pkg;

   localparam logic [1:0] CMD_LOAD   = 2'd0;
   localparam logic [1:0] CMD_SAMPLE = 2'd1;
   localparam logic [1:0] CMD_CLEAR  = 2'd2;

   localparam logic [1:0] CSR_OCTAVES     = 2'd0;
   localparam logic [1:0] CSR_PERSISTENCE = 2'd1;
   localparam logic [1:0] CSR_LACUNARITY  = 2'd2;

   localparam int CSR_W     = 16;
   localparam int COORD_W   = 32;
   localparam int NOISE_W   = 16;
   localparam int T_W       = 16;
   localparam int DIST_W    = T_W + 2;
   localparam int GRAD_W    = DIST_W + 2;
   localparam int FADE_W    = T_W + 1;
   localparam int SCALE_W   = 48;
   localparam int AMP_W     = 32;
   localparam int Q_FRAC    = 12;

   localparam logic [3:0]  OCTAVES_RESET     = 4'd1;
   localparam logic [15:0] PERSISTENCE_RESET = 16'd2048;
   localparam logic [15:0] LACUNARITY_RESET  = 16'd8192;

   typedef struct packed {
      logic [1:0]                command;
      logic [7:0]                table_index;
      logic [7:0]                table_value;
      logic signed [COORD_W-1:0] coord_x;
      logic signed [COORD_W-1:0] coord_y;
      logic signed [COORD_W-1:0] coord_z;
   } work_type;

   typedef struct packed {
      logic [3:0]  octave_count;
      logic [15:0] persistence;
      logic [15:0] lacunarity;
   } cfg_type;

   function automatic logic signed [GRAD_W-1:0] grad(
      input logic [3:0]               h,
      input logic signed [DIST_W-1:0] x,
      input logic signed [DIST_W-1:0] y,
      input logic signed [DIST_W-1:0] z
   );
      logic signed [GRAD_W-1:0] xe;
      logic signed [GRAD_W-1:0] ye;
      logic signed [GRAD_W-1:0] ze;
      logic signed [GRAD_W-1:0] g;
      xe = GRAD_W'(x);
      ye = GRAD_W'(y);
      ze = GRAD_W'(z);
      case (h)
         4'd0:    g = xe + ye;
         4'd1:    g = ye - xe;
         4'd2:    g = xe - ye;
         4'd3:    g = -xe - ye;
         4'd4:    g = xe + ze;
         4'd5:    g = ze - xe;
         4'd6:    g = xe - ze;
         4'd7:    g = -xe - ze;
         4'd8:    g = ye + ze;
         4'd9:    g = ze - ye;
         4'd10:   g = ye - ze;
         4'd11:   g = -ye - ze;
         4'd12:   g = ye + xe;
         4'd13:   g = ze - ye;
         4'd14:   g = ye - xe;
         default: g = -ye - ze;
      endcase
      return g;
   endfunction

endpackage
`default_nettype wire

// ----- design/fgn_bus.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fgn_bus
// Request and response channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface fgn_req_if;
   logic                                valid;
   logic                                ready;
   logic [1:0]                          command;
   logic [7:0]                          table_index;
   logic [7:0]                          table_value;
   logic signed [fgn_pkg::COORD_W-1:0]  coord_x;
   logic signed [fgn_pkg::COORD_W-1:0]  coord_y;
   logic signed [fgn_pkg::COORD_W-1:0]  coord_z;

   modport source (output valid, command, table_index, table_value,
                   coord_x, coord_y, coord_z, input ready);
   modport sink   (input valid, command, table_index, table_value,
                   coord_x, coord_y, coord_z, output ready);
endinterface

interface fgn_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [fgn_pkg::NOISE_W-1:0]  noise_value;
   logic signed [fgn_pkg::NOISE_W-1:0]  min_seen;
   logic signed [fgn_pkg::NOISE_W-1:0]  max_seen;

   modport source (output valid, noise_value, min_seen, max_seen, input ready);
   modport sink   (input valid, noise_value, min_seen, max_seen, output ready);
endinterface
`default_nettype wire

// ----- design/fgn_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fgn_front
// Input stage: take request words, drop unknown commands, pass the rest on.
// ----------------------------------------------------------------------------
module fgn_front (
   input  wire logic               clock,
   input  wire logic               reset,
   fgn_req_if.sink                 req_bus,
   output logic                    push_valid,
   output fgn_pkg::work_type       push_word,
   input  wire logic               push_ready
);

   logic              hold_valid_ff;
   logic              hold_valid_in;
   fgn_pkg::work_type word_ff;
   fgn_pkg::work_type word_in;
   logic              take;
   logic              known;

   assign req_bus.ready = !hold_valid_ff || push_ready;
   assign take          = req_bus.valid && req_bus.ready;
   assign known         = req_bus.command inside
                          {fgn_pkg::CMD_LOAD, fgn_pkg::CMD_SAMPLE, fgn_pkg::CMD_CLEAR};

   always_comb begin
      hold_valid_in = hold_valid_ff && !push_ready;
      word_in       = word_ff;
      if (take) begin
         hold_valid_in       = known;
         word_in.command     = req_bus.command;
         word_in.table_index = req_bus.table_index;
         word_in.table_value = req_bus.table_value;
         word_in.coord_x     = req_bus.coord_x;
         word_in.coord_y     = req_bus.coord_y;
         word_in.coord_z     = req_bus.coord_z;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign push_valid = hold_valid_ff;
   assign push_word  = word_ff;

endmodule
`default_nettype wire

// ----- design/fgn_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fgn_queue
// Two-entry queue between the input stage and the execution engine.
// ----------------------------------------------------------------------------
module fgn_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push_valid,
   input  wire fgn_pkg::work_type  push_word,
   output logic                    push_ready,
   output logic                    pop_valid,
   output fgn_pkg::work_type       pop_word,
   input  wire logic               pop_ready
);

   fgn_pkg::work_type slot_ff [2];
   logic              wr_ptr_ff;
   logic              wr_ptr_in;
   logic              rd_ptr_ff;
   logic              rd_ptr_in;
   logic [1:0]        count_ff;
   logic [1:0]        count_in;
   logic              do_push;
   logic              do_pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_word   = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_word;
      end
   end

endmodule
`default_nettype wire

// ----- design/fgn_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fgn_back
// Execution engine: permutation table, octave sequencer, divider, extremes.
// ----------------------------------------------------------------------------
module fgn_back #(
   parameter int TABLE_SIZE      = 256,
   parameter int MAX_OCTAVES     = 8,
   parameter int COORD_FRAC_BITS = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               pop_valid,
   input  wire fgn_pkg::work_type  pop_word,
   output logic                    pop_ready,
   input  wire fgn_pkg::cfg_type   cfg,
   fgn_rsp_if.source               rsp_bus
);

   localparam int IW     = $clog2(TABLE_SIZE);
   localparam int F      = COORD_FRAC_BITS;
   localparam int OW     = $clog2(MAX_OCTAVES + 1);
   localparam int LOGO   = $clog2(MAX_OCTAVES);
   localparam int GW     = fgn_pkg::GRAD_W;
   localparam int DW     = fgn_pkg::DIST_W;
   localparam int TW     = fgn_pkg::T_W;
   localparam int FW     = fgn_pkg::FADE_W;
   localparam int SW     = fgn_pkg::SCALE_W;
   localparam int AW     = fgn_pkg::AMP_W;
   localparam int NW     = fgn_pkg::NOISE_W;
   localparam int QB     = NW + 1;
   localparam int APW    = GW + AW + 1;
   localparam int ACC_W  = APW + LOGO + 1;
   localparam int ASUM_W = AW + LOGO + 1;
   localparam int LPW    = GW + 1 + FW + 1;
   localparam int HALF   = SW / 2;
   localparam int NRES   = 14;
   localparam int NLERP  = 7;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_SPLIT = 4'd1;
   localparam logic [3:0] S_HASH  = 4'd2;
   localparam logic [3:0] S_LERP  = 4'd3;
   localparam logic [3:0] S_ACC   = 4'd4;
   localparam logic [3:0] S_SCALE = 4'd5;
   localparam logic [3:0] S_DIVI  = 4'd6;
   localparam logic [3:0] S_DIV   = 4'd7;
   localparam logic [3:0] S_DONE  = 4'd8;

   // control
   logic [3:0]  state_ff, state_in;
   logic [4:0]  step_ff, step_in;
   logic        ph_ff, ph_in;
   logic [OW-1:0] oct_ff, oct_in;
   logic [OW-1:0] n_ff, n_in;

   // permutation table
   logic [7:0]    mem [TABLE_SIZE];
   logic          ent_valid_ff [TABLE_SIZE];
   logic          wr_en;
   logic [IW-1:0] wr_addr;
   logic [IW-1:0] rd_addr;
   logic [IW-1:0] rd_addr_ff;
   logic [7:0]    rd_data_ff;
   logic          rd_valid_ff;
   logic [7:0]    rd_word;
   logic [IW+7:0] rd_addr_ext;
   logic [IW+7:0] wr_index_ext;

   // octave datapath
   logic signed [SW-1:0] coord_ff [3];
   logic signed [SW-1:0] coord_in [3];
   logic [IW-1:0]        lat_ff [3];
   logic [TW-1:0]        t_ff [3];
   logic [TW-1:0]        frac_w [3];
   logic [31:0]          tt_ff [3];
   logic [31:0]          t3p_ff [3];
   logic [21:0]          poly_ff [3];
   logic [FW-1:0]        f_ff [3];
   logic [7:0]           res_ff [NRES];
   logic signed [GW-1:0] g_w [8];
   logic signed [GW-1:0] lr_ff [NLERP];
   logic signed [LPW-1:0] lprod_ff;
   logic signed [GW-1:0] la, lb;
   logic [FW-1:0]        lf;
   logic signed [GW:0]   ldiff;
   logic signed [APW-1:0] aprod_ff;
   logic [AW+15:0]       pprod_ff;
   logic [AW-1:0]        amp_ff;
   logic [ASUM_W-1:0]    asum_ff;
   logic signed [ACC_W-1:0] acc_ff;
   logic [HALF+15:0]     sprod_ff;
   logic [1:0]           axis;
   logic signed [HALF+16:0] hprod;
   logic signed [63:0]   scaled;

   // divider and result
   logic [ACC_W-1:0] rem_ff;
   logic [ACC_W-1:0] dsh_ff;
   logic [QB-1:0]    quo_ff;
   logic             neg_ff;
   logic             ge;
   logic signed [NW-1:0] val;
   logic signed [NW-1:0] min_ff, max_ff, min_nx, max_nx;
   logic             extv_ff;
   logic             rsp_valid_ff;
   logic signed [NW-1:0] noise_ff, mins_ff, maxs_ff;
   logic             out_free;
   logic [4:0]       oc5, nc5;

   assign pop_ready = (state_ff == S_IDLE);
   assign out_free  = !rsp_valid_ff || rsp_bus.ready;

   // ---------------------------------------------------------------- table
   assign wr_en        = pop_valid && pop_ready && (pop_word.command == fgn_pkg::CMD_LOAD);
   assign wr_index_ext = (IW + 8)'(pop_word.table_index);
   assign wr_addr      = wr_index_ext[IW-1:0];
   assign rd_addr_ext  = (IW + 8)'(rd_addr_ff);
   assign rd_word      = rd_valid_ff ? rd_data_ff : rd_addr_ext[7:0];

   function automatic logic [IW-1:0] offs(input logic [7:0] p, input logic [IW-1:0] k);
      logic [IW+8:0] s;
      s = (IW + 9)'(p) + (IW + 9)'(k);
      return s[IW-1:0];
   endfunction

   always_comb begin
      case (step_ff)
         5'd0:    rd_addr = lat_ff[0];
         5'd1:    rd_addr = lat_ff[0] + IW'(1);
         5'd2:    rd_addr = offs(res_ff[0], lat_ff[1]);
         5'd3:    rd_addr = offs(res_ff[0], lat_ff[1] + IW'(1));
         5'd4:    rd_addr = offs(res_ff[1], lat_ff[1]);
         5'd5:    rd_addr = offs(res_ff[1], lat_ff[1] + IW'(1));
         5'd6:    rd_addr = offs(res_ff[2], lat_ff[2]);
         5'd7:    rd_addr = offs(res_ff[4], lat_ff[2]);
         5'd8:    rd_addr = offs(res_ff[3], lat_ff[2]);
         5'd9:    rd_addr = offs(res_ff[5], lat_ff[2]);
         5'd10:   rd_addr = offs(res_ff[2], lat_ff[2] + IW'(1));
         5'd11:   rd_addr = offs(res_ff[4], lat_ff[2] + IW'(1));
         5'd12:   rd_addr = offs(res_ff[3], lat_ff[2] + IW'(1));
         5'd13:   rd_addr = offs(res_ff[5], lat_ff[2] + IW'(1));
         default: rd_addr = lat_ff[0];
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= pop_word.table_value;
      end
      rd_data_ff <= mem[rd_addr];
      rd_valid_ff <= ent_valid_ff[rd_addr];
      rd_addr_ff <= rd_addr;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TABLE_SIZE; i++) begin
            ent_valid_ff[i] <= 1'b0;
         end
      end else if (wr_en) begin
         ent_valid_ff[wr_addr] <= 1'b1;
      end
   end

   // ---------------------------------------------------------------- split, fade
   for (genvar a = 0; a < 3; a++) begin : g_axis
      logic [34:0] six_w;
      logic [21:0] poly_w;
      logic [37:0] fp_w;
      if (F >= TW) begin : g_dn
         assign frac_w[a] = coord_ff[a][F-1 -: TW];
      end else begin : g_up
         assign frac_w[a] = {coord_ff[a][F-1:0], {(TW-F){1'b0}}};
      end
      assign six_w  = 35'(tt_ff[a]) * 35'd6;
      assign poly_w = 22'(six_w[34:16]) + 22'd655360 - 22'(22'(t_ff[a]) * 22'd15);
      assign fp_w   = 38'(t3p_ff[a][31:16]) * 38'(poly_ff[a]);
      always_ff @(posedge clock) begin
         tt_ff[a]   <= 32'(t_ff[a]) * 32'(t_ff[a]);
         t3p_ff[a]  <= 32'(tt_ff[a][31:16]) * 32'(t_ff[a]);
         poly_ff[a] <= poly_w;
         f_ff[a]    <= (fp_w[37:16] > 22'd65536) ? FW'(65536) : fp_w[16+FW-1:16];
      end
   end

   // ---------------------------------------------------------------- gradients
   for (genvar c = 0; c < 8; c++) begin : g_corner
      logic signed [DW-1:0] dx, dy, dz;
      assign dx = (c % 2 == 1)       ? {2'b11, t_ff[0]} : {2'b00, t_ff[0]};
      assign dy = ((c / 2) % 2 == 1) ? {2'b11, t_ff[1]} : {2'b00, t_ff[1]};
      assign dz = (c / 4 == 1)       ? {2'b11, t_ff[2]} : {2'b00, t_ff[2]};
      assign g_w[c] = fgn_pkg::grad(res_ff[6+c][3:0], dx, dy, dz);
   end

   always_comb begin
      case (step_ff[2:0])
         3'd0:    begin la = g_w[0];   lb = g_w[1];   lf = f_ff[0]; end
         3'd1:    begin la = g_w[2];   lb = g_w[3];   lf = f_ff[0]; end
         3'd2:    begin la = g_w[4];   lb = g_w[5];   lf = f_ff[0]; end
         3'd3:    begin la = g_w[6];   lb = g_w[7];   lf = f_ff[0]; end
         3'd4:    begin la = lr_ff[0]; lb = lr_ff[1]; lf = f_ff[1]; end
         3'd5:    begin la = lr_ff[2]; lb = lr_ff[3]; lf = f_ff[1]; end
         default: begin la = lr_ff[4]; lb = lr_ff[5]; lf = f_ff[2]; end
      endcase
      ldiff = (GW + 1)'(lb) - (GW + 1)'(la);
   end

   // ---------------------------------------------------------------- scaling
   assign axis   = step_ff[2:1];
   assign hprod  = (HALF + 17)'($signed(coord_ff[axis][SW-1:HALF]))
                   * (HALF + 17)'($signed({1'b0, cfg.lacunarity}));
   assign scaled = (64'(hprod) <<< HALF) + $signed(64'(sprod_ff));

   // ---------------------------------------------------------------- result
   assign ge = (rem_ff >= dsh_ff);

   always_comb begin
      if (!neg_ff) begin
         val = (quo_ff > QB'(32767)) ? NW'(32767) : $signed(quo_ff[NW-1:0]);
      end else begin
         val = (quo_ff > QB'(32768)) ? $signed(NW'(32768)) : $signed(-quo_ff[NW-1:0]);
      end
      if (!extv_ff) begin
         min_nx = val;
         max_nx = val;
      end else begin
         min_nx = (val < min_ff) ? val : min_ff;
         max_nx = (val > max_ff) ? val : max_ff;
      end
      oc5 = 5'(cfg.octave_count);
      if (oc5 == 5'd0) begin
         nc5 = 5'd1;
      end else if (oc5 > 5'(MAX_OCTAVES)) begin
         nc5 = 5'(MAX_OCTAVES);
      end else begin
         nc5 = oc5;
      end
   end

   // ---------------------------------------------------------------- sequencer
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      ph_in    = ph_ff;
      oct_in   = oct_ff;
      n_in     = n_ff;
      case (state_ff)
         S_IDLE: begin
            if (pop_valid && pop_word.command == fgn_pkg::CMD_SAMPLE) begin
               state_in = S_SPLIT;
               oct_in   = '0;
               n_in     = OW'(nc5);
            end
         end
         S_SPLIT: begin
            state_in = S_HASH;
            step_in  = '0;
         end
         S_HASH: begin
            step_in = step_ff + 5'd1;
            if (step_ff == 5'(NRES)) begin
               state_in = S_LERP;
               step_in  = '0;
               ph_in    = 1'b0;
            end
         end
         S_LERP: begin
            ph_in = !ph_ff;
            if (ph_ff) begin
               step_in = step_ff + 5'd1;
               if (step_ff == 5'(NLERP - 1)) begin
                  state_in = S_ACC;
                  step_in  = '0;
               end
            end
         end
         S_ACC: begin
            ph_in = !ph_ff;
            if (ph_ff) begin
               oct_in  = oct_ff + OW'(1);
               step_in = '0;
               state_in = (oct_ff + OW'(1) == n_ff) ? S_DIVI : S_SCALE;
            end
         end
         S_SCALE: begin
            step_in = step_ff + 5'd1;
            if (step_ff == 5'd5) begin
               state_in = S_SPLIT;
            end
         end
         S_DIVI: begin
            state_in = S_DIV;
            step_in  = 5'(QB - 1);
         end
         S_DIV: begin
            step_in = step_ff - 5'd1;
            if (step_ff == 5'd0) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= '0;
         ph_ff        <= 1'b0;
         oct_ff       <= '0;
         n_ff         <= OW'(1);
         extv_ff      <= 1'b0;
         min_ff       <= '0;
         max_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         ph_ff    <= ph_in;
         oct_ff   <= oct_in;
         n_ff     <= n_in;
         if (pop_valid && pop_ready && pop_word.command == fgn_pkg::CMD_CLEAR) begin
            extv_ff <= 1'b0;
            min_ff  <= '0;
            max_ff  <= '0;
         end else if (state_ff == S_DONE && out_free) begin
            extv_ff <= 1'b1;
            min_ff  <= min_nx;
            max_ff  <= max_nx;
         end
         if (state_ff == S_DONE && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         coord_in[a] = coord_ff[a];
      end
      if (state_ff == S_IDLE) begin
         coord_in[0] = SW'(pop_word.coord_x);
         coord_in[1] = SW'(pop_word.coord_y);
         coord_in[2] = SW'(pop_word.coord_z);
      end else if (state_ff == S_SCALE && step_ff[0]) begin
         coord_in[axis] = scaled[SW+fgn_pkg::Q_FRAC-1:fgn_pkg::Q_FRAC];
      end
   end

   always_ff @(posedge clock) begin
      for (int a = 0; a < 3; a++) begin
         coord_ff[a] <= coord_in[a];
      end
      case (state_ff)
         S_IDLE: begin
            amp_ff  <= AW'(1 << fgn_pkg::Q_FRAC);
            asum_ff <= '0;
            acc_ff  <= '0;
         end
         S_SPLIT: begin
            for (int a = 0; a < 3; a++) begin
               lat_ff[a] <= coord_ff[a][F+IW-1:F];
               t_ff[a]   <= frac_w[a];
            end
         end
         S_HASH: begin
            if (step_ff != 5'd0) begin
               res_ff[4'(step_ff - 5'd1)] <= rd_word;
            end
         end
         S_LERP: begin
            if (!ph_ff) begin
               lprod_ff <= LPW'(ldiff) * LPW'($signed({1'b0, lf}));
            end else begin
               lr_ff[step_ff[2:0]] <= la + GW'(lprod_ff >>> TW);
            end
         end
         S_ACC: begin
            if (!ph_ff) begin
               aprod_ff <= APW'(lr_ff[NLERP-1]) * $signed({1'b0, amp_ff});
               pprod_ff <= (AW + 16)'(amp_ff) * (AW + 16)'(cfg.persistence);
               asum_ff  <= asum_ff + ASUM_W'(amp_ff);
            end else begin
               acc_ff <= acc_ff + ACC_W'(aprod_ff);
               amp_ff <= (pprod_ff[AW+15:fgn_pkg::Q_FRAC] > (AW + 4)'({AW{1'b1}}))
                         ? {AW{1'b1}} : pprod_ff[AW+fgn_pkg::Q_FRAC-1:fgn_pkg::Q_FRAC];
            end
         end
         S_SCALE: begin
            if (!step_ff[0]) begin
               sprod_ff <= (HALF + 16)'(coord_ff[axis][HALF-1:0])
                           * (HALF + 16)'(cfg.lacunarity);
            end
         end
         S_DIVI: begin
            neg_ff <= acc_ff[ACC_W-1];
            rem_ff <= acc_ff[ACC_W-1] ? ACC_W'(-acc_ff) : ACC_W'(acc_ff);
            dsh_ff <= ACC_W'(asum_ff) << QB;
            quo_ff <= '0;
         end
         S_DIV: begin
            if (ge) begin
               rem_ff <= rem_ff - dsh_ff;
            end
            quo_ff <= {quo_ff[QB-2:0], ge};
            dsh_ff <= dsh_ff >> 1;
         end
         S_DONE: begin
            if (out_free) begin
               noise_ff <= val;
               mins_ff  <= min_nx;
               maxs_ff  <= max_nx;
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.noise_value = noise_ff;
   assign rsp_bus.min_seen    = mins_ff;
   assign rsp_bus.max_seen    = maxs_ff;

   a_oct_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_HASH || state_ff == S_LERP) |-> (oct_ff < n_ff))
      else $error("octave counter beyond octave count");

   a_ext_order: assert property (@(posedge clock) disable iff (reset)
      extv_ff |-> (min_ff <= max_ff))
      else $error("running minimum above running maximum");

   a_ext_clear: assert property (@(posedge clock) disable iff (reset)
      !extv_ff |-> (min_ff == '0 && max_ff == '0))
      else $error("extremes not zero while invalid");

   a_div_rem: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && !quo_ff[QB-1]) |-> (rem_ff < (ACC_W'(asum_ff) << 1)))
      else $error("divider remainder not below divisor");

   a_rsp_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_DONE))
      else $error("response raised outside result state");

endmodule
`default_nettype wire

// ----- design/fractal_gradient_noise_3d_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fractal_gradient_noise_3d_top
// Fractal 3D gradient noise over a loadable permutation table.
// ----------------------------------------------------------------------------
// A load or clear word is handled while the engine stays idle; the time a
// sample of n octaves takes is set by the chain of dependent permutation
// table reads (one read port, 14 reads per octave), the shared lerp
// multiplier (7 lerps, each a multiply then an add) and a 17-step
// restoring divider at the end. Up to three words are buffered ahead of
// the engine, so the request side takes that many more words while a
// result waits on the response side. TABLE_SIZE must be a power of two.
// ----------------------------------------------------------------------------
module fractal_gradient_noise_3d_top #(
   parameter int TABLE_SIZE      = 256,
   parameter int MAX_OCTAVES     = 8,
   parameter int COORD_FRAC_BITS = 16
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   fgn_req_if.sink                          req_bus,
   fgn_rsp_if.source                        rsp_bus,
   input  wire logic                        csr_wr_en,
   input  wire logic [1:0]                  csr_index,
   input  wire logic [fgn_pkg::CSR_W-1:0]   csr_wdata
);

   fgn_pkg::cfg_type  cfg_ff;
   fgn_pkg::cfg_type  cfg_in;
   logic              push_valid;
   logic              push_ready;
   fgn_pkg::work_type push_word;
   logic              pop_valid;
   logic              pop_ready;
   fgn_pkg::work_type pop_word;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            fgn_pkg::CSR_OCTAVES:     cfg_in.octave_count = csr_wdata[3:0];
            fgn_pkg::CSR_PERSISTENCE: cfg_in.persistence  = csr_wdata;
            fgn_pkg::CSR_LACUNARITY:  cfg_in.lacunarity   = csr_wdata;
            default:                  cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.octave_count <= fgn_pkg::OCTAVES_RESET;
         cfg_ff.persistence  <= fgn_pkg::PERSISTENCE_RESET;
         cfg_ff.lacunarity   <= fgn_pkg::LACUNARITY_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   fgn_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .push_valid (push_valid),
      .push_word  (push_word),
      .push_ready (push_ready)
   );

   fgn_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_word  (push_word),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_word   (pop_word),
      .pop_ready  (pop_ready)
   );

   fgn_back #(
      .TABLE_SIZE      (TABLE_SIZE),
      .MAX_OCTAVES     (MAX_OCTAVES),
      .COORD_FRAC_BITS (COORD_FRAC_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_word  (pop_word),
      .pop_ready (pop_ready),
      .cfg       (cfg_ff),
      .rsp_bus   (rsp_bus)
   );

endmodule
`default_nettype wire
